/* rtl/uniform_grid_cell_mapper_macros.svh */
// assertion macros for the grid cell mapper
`ifndef UNIFORM_GRID_CELL_MAPPER_MACROS_SVH
`define UNIFORM_GRID_CELL_MAPPER_MACROS_SVH

`ifndef ASSERT_OFF
`define UGCM_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("same-cycle check failed");
`define UGCM_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle check failed");
`else
`define UGCM_ASSERT_IMP(label, clk, rst, lhs, rhs)
`define UGCM_ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif

`endif

/* rtl/ugcm_pkg.sv */
package ugcm_pkg;

   // quotient bits resolved per stage in the small-divisor dividers
   localparam int DIV_STEP = 4;
   localparam int DEPTH = 24;

   localparam int ST_SUB   = 1;
   localparam int ST_MUL0  = 2;
   localparam int ST_CHK   = 3;
   localparam int ST_POSD0 = 4;
   localparam int ST_POSD3 = 7;
   localparam int ST_CLAMP = 8;
   localparam int ST_IDMUL = 9;
   localparam int ST_IDSUM = 10;
   localparam int ST_DIVA  = 2;
   localparam int ST_DIVB  = 8;
   localparam int ST_BMUL  = 12;
   localparam int ST_DIVC  = 13;
   localparam int ST_OUT   = 23;

   typedef enum logic [2:0] {
      REG_MIN_X,
      REG_MIN_Y,
      REG_MIN_Z,
      REG_SIZE_X,
      REG_SIZE_Y,
      REG_SIZE_Z,
      REG_DIMS
   } reg_idx_type;

   typedef struct packed {
      logic             cmd;
      logic [23:0]      qc;
      logic [2:0][31:0] pos;
      logic [2:0]       neg;
      logic [2:0][39:0] num0;
      logic [2:0]       sat;
      logic [2:0][30:0] rem0;
      logic [2:0][7:0]  nlo;
      logic [2:0][7:0]  q0;
      logic [23:0]      sid;
      logic             bad;
      logic [15:0]      prod_b;
      logic [23:0]      prod_a;
      logic [23:0]      cell_id;
      logic [2:0][7:0]  ci;
      logic [2:0][38:0] lo_num;
      logic [2:0][38:0] hi_num;
      logic             res_valid;
      logic [2:0][31:0] res_lo;
      logic [2:0][31:0] res_hi;
   } pipe_type;

   // min plus nonnegative offset, clipped at the top of the signed range
   function automatic logic [31:0] sat_bound(input logic [31:0] mn, input logic [30:0] q);
      logic [33:0] sum;
      sum = {{2{mn[31]}}, mn} + {3'b000, q};
      if (!sum[33] && (sum[32] || sum[31])) begin
         return 32'h7fff_ffff;
      end
      return sum[31:0];
   endfunction

endpackage

/* rtl/ugcm_div8.sv */
module ugcm_div8 import ugcm_pkg::*; #(
   parameter int NUM_W = 24,
   localparam int STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP,
   localparam int PAD_W = STAGES * DIV_STEP
) (
   input  logic              clock,
   input  logic [STAGES-1:0] load,
   input  logic [7:0]        den,
   input  logic [NUM_W-1:0]  num,
   output logic [NUM_W-1:0]  quo,
   output logic [7:0]        rem
);

   logic [7:0]       rem_ff [STAGES];
   logic [7:0]       rem_in [STAGES];
   logic [PAD_W-1:0] work_ff [STAGES];
   logic [PAD_W-1:0] work_in [STAGES];

   // restoring division, numerator bits leave the top of work as quotient bits enter
   always_comb begin
      logic [7:0]       r;
      logic [PAD_W-1:0] w;
      logic [8:0]       t9;
      logic             qb;
      for (int s = 0; s < STAGES; s++) begin
         if (s == 0) begin
            r = 8'd0;
            w = PAD_W'(num);
         end else begin
            r = rem_ff[s-1];
            w = work_ff[s-1];
         end
         for (int j = 0; j < DIV_STEP; j++) begin
            t9 = {r, w[PAD_W-1]};
            if (t9 >= {1'b0, den}) begin
               r  = 8'(t9 - {1'b0, den});
               qb = 1'b1;
            end else begin
               r  = t9[7:0];
               qb = 1'b0;
            end
            w = {w[PAD_W-2:0], qb};
         end
         rem_in[s]  = r;
         work_in[s] = w;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (load[s]) begin
            rem_ff[s]  <= rem_in[s];
            work_ff[s] <= work_in[s];
         end
      end
   end

   assign quo = work_ff[STAGES-1][NUM_W-1:0];
   assign rem = rem_ff[STAGES-1];

endmodule

/* rtl/uniform_grid_cell_mapper.sv */
// channel   dir  handshake               payload
// req       in   req_tvalid/req_tready   tdata pos_x,pos_y,pos_z,query_cell; tuser cmd
// rsp       out  rsp_tvalid/rsp_tready   tdata cell_id,lo_x..hi_z; tuser valid_res
// csr       in   csr_valid/csr_ready     csr_index, csr_data
//
// one beat per cycle in, unless back-pressure on rsp stalls the pipeline
// most of the pipeline is spent in the 4-bit-per-stage dividers by the per-axis cell count
// each stage holds its beat when the next one cannot load, so bubbles close up on a stall
// reset clears all valid bits and loads the box and grid registers with their defaults
`include "uniform_grid_cell_mapper_macros.svh"

module uniform_grid_cell_mapper import ugcm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,  // pos_x, pos_y, pos_z, query_cell
   input  logic         req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [215:0] rsp_tdata,  // cell_id, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
   output logic         rsp_tuser,  // valid_res
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   logic [2:0][31:0] min_ff;
   logic [2:0][30:0] size_ff;
   logic [23:0]      dims_ff;
   logic [15:0]      nxny_ff;
   logic [23:0]      tot_ff;

   logic [2:0][7:0]  n_e;
   logic [2:0][30:0] s_e;

   pipe_type         pipe_ff [DEPTH];
   pipe_type         pipe_in [DEPTH];
   logic [DEPTH-1:0] v_ff;
   logic [DEPTH-1:0] load;

   logic [23:0]      quo_a;
   logic [7:0]       rem_a;
   logic [15:0]      quo_b;
   logic [7:0]       rem_b;
   logic [2:0][38:0] lo_q;
   logic [2:0][38:0] hi_q;
   logic [2:0][7:0]  unused_lo_r;
   logic [2:0][7:0]  unused_hi_r;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= '0;
         size_ff <= {3{31'd65536}};
         dims_ff <= 24'h01_0101;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MIN_X:  min_ff[0] <= csr_data;
            REG_MIN_Y:  min_ff[1] <= csr_data;
            REG_MIN_Z:  min_ff[2] <= csr_data;
            REG_SIZE_X: size_ff[0] <= csr_data[30:0];
            REG_SIZE_Y: size_ff[1] <= csr_data[30:0];
            REG_SIZE_Z: size_ff[2] <= csr_data[30:0];
            REG_DIMS:   dims_ff <= csr_data[23:0];
            default: begin
            end
         endcase
      end
   end

   // zero counts and zero extents act as one
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         n_e[a] = (dims_ff[8*a +: 8] == 8'd0) ? 8'd1 : dims_ff[8*a +: 8];
         s_e[a] = (size_ff[a] == 31'd0) ? 31'd1 : size_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      nxny_ff <= 16'(n_e[0]) * 16'(n_e[1]);
      tot_ff  <= 24'(nxny_ff) * 24'(n_e[2]);
   end

   // a stage loads when it is empty or its successor loads
   always_comb begin
      load[DEPTH-1] = !v_ff[DEPTH-1] || rsp_tready;
      for (int k = DEPTH - 2; k >= 0; k--) begin
         load[k] = !v_ff[k] || load[k+1];
      end
   end

   assign req_tready = load[0];

   always_comb begin
      logic [32:0]     d33;
      logic [31:0]     r32;
      logic [7:0]      nm1;
      logic [8:0]      i9;
      logic [2:0][7:0] cv;
      logic            qb;
      pipe_type        p;
      pipe_in[0]         = '0;
      pipe_in[0].cmd     = req_tuser;
      pipe_in[0].pos[0]  = req_tdata[31:0];
      pipe_in[0].pos[1]  = req_tdata[63:32];
      pipe_in[0].pos[2]  = req_tdata[95:64];
      pipe_in[0].qc      = req_tdata[119:96];
      for (int k = 1; k < DEPTH; k++) begin
         p = pipe_ff[k-1];
         pipe_in[k] = p;
         case (k)
            ST_SUB: begin
               for (int a = 0; a < 3; a++) begin
                  d33 = {p.pos[a][31], p.pos[a]} - {min_ff[a][31], min_ff[a]};
                  pipe_in[k].neg[a]  = d33[32];
                  pipe_in[k].num0[a] = {8'd0, d33[31:0]};
               end
               pipe_in[k].sid = p.qc - 24'd1;
            end
            ST_MUL0: begin
               for (int a = 0; a < 3; a++) begin
                  pipe_in[k].num0[a] = 40'(p.num0[a][31:0]) * 40'(n_e[a]);
               end
            end
            ST_CHK: begin
               for (int a = 0; a < 3; a++) begin
                  pipe_in[k].sat[a]  = p.num0[a] >= {1'b0, s_e[a], 8'h00};
                  pipe_in[k].rem0[a] = p.num0[a][38:8];
                  pipe_in[k].nlo[a]  = p.num0[a][7:0];
               end
               pipe_in[k].bad = (p.qc == 24'd0) || (p.qc > tot_ff);
            end
            ST_POSD0, ST_POSD0 + 1, ST_POSD0 + 2, ST_POSD3: begin
               // two quotient bits per stage against the 31-bit extent
               for (int a = 0; a < 3; a++) begin
                  for (int j = 0; j < 2; j++) begin
                     r32 = {pipe_in[k].rem0[a], pipe_in[k].nlo[a][7]};
                     if (r32 >= {1'b0, s_e[a]}) begin
                        pipe_in[k].rem0[a] = 31'(r32 - {1'b0, s_e[a]});
                        qb = 1'b1;
                     end else begin
                        pipe_in[k].rem0[a] = r32[30:0];
                        qb = 1'b0;
                     end
                     pipe_in[k].nlo[a] = {pipe_in[k].nlo[a][6:0], qb};
                  end
               end
            end
            ST_CLAMP: begin
               for (int a = 0; a < 3; a++) begin
                  nm1 = n_e[a] - 8'd1;
                  if (p.neg[a]) begin
                     pipe_in[k].q0[a] = 8'd0;
                  end else if (p.sat[a] || p.nlo[a] > nm1) begin
                     pipe_in[k].q0[a] = nm1;
                  end else begin
                     pipe_in[k].q0[a] = p.nlo[a];
                  end
               end
               pipe_in[k].ci[0] = rem_a;
            end
            ST_IDMUL: begin
               pipe_in[k].prod_a = 24'(p.q0[2]) * 24'(nxny_ff);
               pipe_in[k].prod_b = 16'(p.q0[1]) * 16'(n_e[0]);
            end
            ST_IDSUM: begin
               pipe_in[k].cell_id = p.prod_a + 24'(p.prod_b) + 24'(p.q0[0]) + 24'd1;
            end
            ST_BMUL: begin
               cv[0] = p.ci[0];
               cv[1] = rem_b;
               cv[2] = quo_b[7:0];
               pipe_in[k].ci = cv;
               for (int a = 0; a < 3; a++) begin
                  i9 = {1'b0, cv[a]} + 9'd1;
                  pipe_in[k].lo_num[a] = 39'(cv[a]) * 39'(s_e[a]);
                  pipe_in[k].hi_num[a] = 39'(i9) * 39'(s_e[a]);
               end
            end
            ST_OUT: begin
               pipe_in[k].res_lo = '0;
               pipe_in[k].res_hi = '0;
               if (!p.cmd) begin
                  pipe_in[k].res_valid = 1'b1;
               end else begin
                  pipe_in[k].cell_id = 24'd0;
                  pipe_in[k].res_valid = !p.bad;
                  if (!p.bad) begin
                     for (int a = 0; a < 3; a++) begin
                        pipe_in[k].res_lo[a] = sat_bound(min_ff[a], lo_q[a][30:0]);
                        pipe_in[k].res_hi[a] = sat_bound(min_ff[a], hi_q[a][30:0]);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         if (load[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < DEPTH; k++) begin
            if (load[k]) begin
               v_ff[k] <= (k == 0) ? req_tvalid : v_ff[k-1];
            end
         end
      end
   end

   // id minus one split into x and the rest, then the rest into y and z
   ugcm_div8 #(.NUM_W(24)) u_div_x (
      .clock (clock),
      .load  (load[ST_DIVA +: 6]),
      .den   (n_e[0]),
      .num   (pipe_ff[ST_DIVA-1].sid),
      .quo   (quo_a),
      .rem   (rem_a)
   );

   ugcm_div8 #(.NUM_W(16)) u_div_y (
      .clock (clock),
      .load  (load[ST_DIVB +: 4]),
      .den   (n_e[1]),
      .num   (quo_a[15:0]),
      .quo   (quo_b),
      .rem   (rem_b)
   );

   for (genvar a = 0; a < 3; a++) begin : g_bound
      ugcm_div8 #(.NUM_W(39)) u_div_lo (
         .clock (clock),
         .load  (load[ST_DIVC +: 10]),
         .den   (n_e[a]),
         .num   (pipe_ff[ST_DIVC-1].lo_num[a]),
         .quo   (lo_q[a]),
         .rem   (unused_lo_r[a])
      );
      ugcm_div8 #(.NUM_W(39)) u_div_hi (
         .clock (clock),
         .load  (load[ST_DIVC +: 10]),
         .den   (n_e[a]),
         .num   (pipe_ff[ST_DIVC-1].hi_num[a]),
         .quo   (hi_q[a]),
         .rem   (unused_hi_r[a])
      );
   end

   assign rsp_tvalid = v_ff[DEPTH-1];
   assign rsp_tuser  = pipe_ff[DEPTH-1].res_valid;
   assign rsp_tdata  = {pipe_ff[DEPTH-1].res_hi[2], pipe_ff[DEPTH-1].res_hi[1],
                        pipe_ff[DEPTH-1].res_hi[0], pipe_ff[DEPTH-1].res_lo[2],
                        pipe_ff[DEPTH-1].res_lo[1], pipe_ff[DEPTH-1].res_lo[0],
                        pipe_ff[DEPTH-1].cell_id};

   `UGCM_ASSERT_NEXT(a_accept_fills, clock, reset, req_tvalid && req_tready, v_ff[0])
   `UGCM_ASSERT_IMP(a_pos_valid, clock, reset, v_ff[DEPTH-1] && !pipe_ff[DEPTH-1].cmd, rsp_tuser && rsp_tdata[23:0] != 24'd0)
   `UGCM_ASSERT_IMP(a_bad_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0)

endmodule
